>>> src/ritt_pkg.sv
// ----------------------------------------------------------------------------
// ritt_pkg: shared types and constants for the radix integer-to-text block
// Field widths, alphabet layout, register indexes, character codes, FSM
// states and the control/status bundles between the top level and divider.
// ----------------------------------------------------------------------------
package ritt_pkg;

  // Field and register widths
  localparam int DATA_W        = 32;
  localparam int SYM_W         = 8;
  localparam int WORD_W        = 64;
  localparam int LEN_W         = 6;
  localparam int ALPHA_WORDS   = 5;
  localparam int ALPHA_SYMS    = ALPHA_WORDS * WORD_W / SYM_W;
  localparam int CFG_IDX_W     = 3;
  localparam int MAX_RADIX_DEF = 40;

  // Worst case digit count (base 2, 32-bit magnitude)
  localparam int MAX_DIGITS    = DATA_W;

  // Divider: quotient bits resolved per cycle
  localparam int STEP_BITS     = 8;
  localparam int DIV_STEPS     = DATA_W / STEP_BITS;

  // Letters and digits are all below 8'h80, so a 7-bit seen map covers them
  localparam int SEEN_IDX_W    = 7;
  localparam int SEEN_W        = 1 << SEEN_IDX_W;

  // Register index of the radix length; alphabet words sit below it
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX_LEN = 3'd5;

  // Character codes
  localparam logic [SYM_W-1:0] CH_0     = 8'h30;
  localparam logic [SYM_W-1:0] CH_9     = 8'h39;
  localparam logic [SYM_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [SYM_W-1:0] CH_LO_Z  = 8'h7a;
  localparam logic [SYM_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [SYM_W-1:0] CH_UP_Z  = 8'h5a;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [SYM_W-1:0] CH_NONE  = 8'h00;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SIGN,
    ST_EMIT,
    ST_ERR
  } ritt_state_t;

  // Top level to divider
  typedef struct packed {
    logic load;   // take a new dividend
    logic start;  // run one division by the radix
  } div_ctl_t;

  // Divider to top level
  typedef struct packed {
    logic busy;
    logic done;       // one-cycle pulse, digit and quotient are final
    logic quot_zero;  // quotient held in the divider is zero
  } div_sts_t;

  // True for '0'..'9', 'a'..'z', 'A'..'Z'
  function automatic logic is_alnum(input logic [SYM_W-1:0] c);
    return ((c >= CH_0) && (c <= CH_9)) ||
           ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

endpackage

>>> src/ritt_in_if.sv
// ----------------------------------------------------------------------------
// ritt_in_if: input request channel
// Carries one signed integer per request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ritt_in_if;

  logic                              valid;
  logic                              ready;
  logic signed [ritt_pkg::DATA_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);

endinterface

>>> src/ritt_out_if.sv
// ----------------------------------------------------------------------------
// ritt_out_if: result request channel
// Carries one text character per request with last and error flags.
// ----------------------------------------------------------------------------
interface ritt_out_if;

  logic                       valid;
  logic                       ready;
  logic [ritt_pkg::SYM_W-1:0] symbol;
  logic                       is_last;
  logic                       bad_alphabet;

  modport source (output valid, output symbol, output is_last, output bad_alphabet,
                  input ready);
  modport sink   (input valid, input symbol, input is_last, input bad_alphabet,
                  output ready);

endinterface

>>> src/radix_integer_to_text.sv
// ----------------------------------------------------------------------------
// radix_integer_to_text: signed integer to text in a configured radix
// Each value is taken in idle, its alphabet checked one symbol at a time
//   up to the radix length, its digits divided out, then one character per cycle
//   while out is ready. Each digit runs through the shared divider (start,
//   4 steps of 8 quotient bits, done) and onto a digit stack; the next value
//   waits for the last char. Invalid alphabet: one error char.
// Reset: sync, no clear pass; control/config regs to 0 (alphabet invalid).
// ----------------------------------------------------------------------------
module radix_integer_to_text
  import ritt_pkg::*;
#(
  parameter int MAX_RADIX = MAX_RADIX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ritt_in_if.sink              in_ch,
  ritt_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  localparam int DIGIT_W = $clog2(MAX_RADIX);
  localparam int CNT_W   = $clog2(MAX_DIGITS + 1);

  // Configuration registers
  logic [WORD_W-1:0]           alpha_r [ALPHA_WORDS];
  logic [LEN_W-1:0]            len_r;
  logic [ALPHA_SYMS*SYM_W-1:0] alpha_flat;

  // Sequencer and datapath
  ritt_state_t           state_r, state_nxt;
  logic                  neg_r, neg_nxt;
  logic [LEN_W-1:0]      idx_r, idx_nxt;
  logic [SEEN_W-1:0]     seen_r, seen_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIGIT_W-1:0]    stk_r [MAX_DIGITS];
  logic [DIGIT_W-1:0]    stk_nxt [MAX_DIGITS];

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]      out_sym_r, out_sym_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_bad_r, out_bad_nxt;

  // Helpers
  logic                  in_ready, acc;
  logic [DATA_W-1:0]     raw, mag;
  logic                  len_ok, chk_bad, chk_last, more_digits, slot_free;
  logic [LEN_W-1:0]      sel_idx;
  logic [SYM_W-1:0]      sel_sym;
  logic                  out_load;
  logic [SYM_W-1:0]      load_sym;
  logic                  load_last, load_bad;
  div_ctl_t              div_ctl;
  div_sts_t              div_sts;
  logic [DIGIT_W-1:0]    div_digit;

  // Configuration writes; indexes past the radix length are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < ALPHA_WORDS; w++) begin
        alpha_r[w] <= '0;
      end
      len_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index < CFG_RADIX_LEN) begin
        alpha_r[cfg_index] <= cfg_data;
      end else if (cfg_index == CFG_RADIX_LEN) begin
        len_r <= cfg_data[LEN_W-1:0];
      end
    end
  end

  for (genvar w = 0; w < ALPHA_WORDS; w++) begin : g_flat
    assign alpha_flat[w*WORD_W +: WORD_W] = alpha_r[w];
  end

  // Symbol lookup, shared by the alphabet check and the digit output
  assign sel_sym = (sel_idx < LEN_W'(ALPHA_SYMS)) ? alpha_flat[sel_idx*SYM_W +: SYM_W]
                                                  : CH_NONE;

  // Request side and status terms
  assign acc         = in_ch.valid && in_ready;
  assign raw         = in_ch.value;
  assign mag         = raw[DATA_W-1] ? ('0 - raw) : raw;
  assign len_ok      = (len_r >= LEN_W'(2)) && (len_r <= LEN_W'(MAX_RADIX));
  assign chk_bad     = !is_alnum(sel_sym) || seen_r[sel_sym[SEEN_IDX_W-1:0]];
  assign chk_last    = (idx_r == (len_r - LEN_W'(1)));
  assign more_digits = !div_sts.quot_zero && (cnt_r < CNT_W'(MAX_DIGITS - 1));
  assign slot_free   = !out_valid_r || out_ch.ready;

  // Divider
  ritt_div #(
    .MAX_RADIX (MAX_RADIX)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .load_val (mag),
    .radix    ((DIGIT_W+1)'(len_r)),
    .sts      (div_sts),
    .digit    (div_digit)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) state_nxt = len_ok ? ST_CHECK : ST_ERR;
      end
      ST_CHECK: begin
        if (chk_bad)       state_nxt = ST_ERR;
        else if (chk_last) state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_sts.done) begin
          if (more_digits) state_nxt = ST_DIV_GO;
          else             state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free && (cnt_r == CNT_W'(1))) state_nxt = ST_IDLE;
      end
      ST_ERR: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready      = 1'b0;
    div_ctl.load  = acc;
    div_ctl.start = 1'b0;
    sel_idx       = idx_r;
    out_load      = 1'b0;
    load_sym      = CH_NONE;
    load_last     = 1'b0;
    load_bad      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_DIV_GO: begin
        div_ctl.start = 1'b1;
      end
      ST_SIGN: begin
        out_load = slot_free;
        load_sym = CH_MINUS;
      end
      ST_EMIT: begin
        sel_idx   = LEN_W'(stk_r[0]);
        out_load  = slot_free;
        load_sym  = sel_sym;
        load_last = (cnt_r == CNT_W'(1));
      end
      ST_ERR: begin
        out_load  = slot_free;
        load_last = 1'b1;
        load_bad  = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_ch.ready = in_ready;

  // Datapath next values
  always_comb begin
    neg_nxt = neg_r;
    idx_nxt = idx_r;
    seen_nxt = seen_r;
    cnt_nxt = cnt_r;
    stk_nxt = stk_r;
    // new request
    if (acc) begin
      neg_nxt  = raw[DATA_W-1];
      idx_nxt  = '0;
      seen_nxt = '0;
      cnt_nxt  = '0;
    end
    // alphabet check: mark symbol as seen
    if ((state_r == ST_CHECK) && !chk_bad) begin
      seen_nxt[sel_sym[SEEN_IDX_W-1:0]] = 1'b1;
      idx_nxt = idx_r + LEN_W'(1);
    end
    // push digit, least significant first
    if ((state_r == ST_DIV_WAIT) && div_sts.done) begin
      stk_nxt[0] = div_digit;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        stk_nxt[i] = stk_r[i-1];
      end
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    // pop digit, most significant first
    if ((state_r == ST_EMIT) && slot_free) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        stk_nxt[i] = stk_r[i+1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // Output register next values
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_sym_nxt   = load_sym;
      out_last_nxt  = load_last;
      out_bad_nxt   = load_bad;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    seen_r     <= seen_nxt;
    stk_r      <= stk_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.symbol       = out_sym_r;
  assign out_ch.is_last      = out_last_r;
  assign out_ch.bad_alphabet = out_bad_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_DIGITS))
    else $error("digit stack overflow");

  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == ST_DIV_WAIT))
    else $error("divider finished outside the wait state");

  a_wait_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_WAIT) |-> (div_sts.busy || div_sts.done))
    else $error("waiting on an idle divider");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (cnt_r != '0))
    else $error("emitting from an empty digit stack");

  a_check_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (idx_r < len_r))
    else $error("alphabet check ran past the radix length");

endmodule

>>> src/ritt_div.sv
// ----------------------------------------------------------------------------
// ritt_div: digit-serial divider by the radix
// Holds the running magnitude in a shift register and divides it by the
// radix, resolving STEP_BITS quotient bits per cycle with a narrow
// remainder. The quotient replaces the magnitude for the next digit.
// ----------------------------------------------------------------------------
module ritt_div
  import ritt_pkg::*;
#(
  parameter  int MAX_RADIX = MAX_RADIX_DEF,
  localparam int DIGIT_W   = $clog2(MAX_RADIX)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  div_ctl_t            ctl,
  input  logic [DATA_W-1:0]   load_val,
  input  logic [DIGIT_W:0]    radix,
  output div_sts_t            sts,
  output logic [DIGIT_W-1:0]  digit
);

  localparam int STEP_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  logic [DATA_W-1:0]     val_r, val_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [STEP_CNT_W-1:0] step_r;
  logic                  busy_r, done_r;

  // Restoring division over one slice of the magnitude, MSB first
  always_comb begin
    logic [DIGIT_W:0]     t;
    logic [DIGIT_W-1:0]   r;
    logic [STEP_BITS-1:0] q;
    r = rem_r;
    q = '0;
    for (int k = 0; k < STEP_BITS; k++) begin
      t = {r, val_r[DATA_W-1-k]};
      if (t >= radix) begin
        r                 = DIGIT_W'(t - radix);
        q[STEP_BITS-1-k]  = 1'b1;
      end else begin
        r = DIGIT_W'(t);
      end
    end
    rem_nxt = r;
    val_nxt = {val_r[DATA_W-STEP_BITS-1:0], q};
  end

  // Magnitude / quotient and remainder registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val_r <= load_val;
    end else if (busy_r) begin
      val_r <= val_nxt;
    end
    if (ctl.start) begin
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
    end
  end

  // Step sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          step_r <= '0;
        end
      end
    end
  end

  assign sts.busy      = busy_r;
  assign sts.done      = done_r;
  assign sts.quot_zero = (val_r == '0);
  assign digit         = rem_r;

  // Checks
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r)
    else $error("divider started while busy");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r))
    else $error("divider done while still busy");

  a_step_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != '0) |-> busy_r)
    else $error("divider step count moved outside a run");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: radix integer-to-text converter
// Loads digit alphabets through the register port and streams signed values
// through the input channel. A directed table covers the value extremes,
// the edges of the radix range and every way an alphabet can be rejected.
// Random blocks of values follow, each block under a fresh random alphabet
// and its own mix of sender gaps and receiver stalls. Every character that
// comes out is checked against table text or text from a local model of the block.
// ----------------------------------------------------------------------------
module testbench;
  import ritt_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 400;
  localparam int RAND_BLOCKS    = 26;
  localparam int BLOCK_ITEMS    = 22;
  localparam int BAD_ITEMS      = 4;
  localparam int TIMEOUT_CYCLES = 1000000;

  // Register map: alphabet words sit at indexes 0..4, radix length at 5
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum {ROW_PREDICT, ROW_TEXT, ROW_BAD} row_kind_t;
  typedef enum {FLAW_NONE, FLAW_DUP, FLAW_CHAR, FLAW_LEN} flaw_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             is_last;
    logic             bad_alphabet;
  } char_t;

  typedef struct {
    string            syms;
    logic [LEN_W-1:0] len;
    logic [SYM_W-1:0] fill;
  } alpha_spec_t;

  typedef struct {
    int                alpha;
    logic [DATA_W-1:0] value;
    row_kind_t         kind;
    string             text;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  ritt_in_if  in_ch ();
  ritt_out_if out_ch ();

  radix_integer_to_text uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Local copy of the register file
  logic [WORD_W-1:0] alpha_word_m [ALPHA_WORDS];
  logic [LEN_W-1:0]  radix_len_m;

  // Staging bytes for the next alphabet load
  logic [SYM_W-1:0] alpha_buf [ALPHA_SYMS];

  char_t pending_chars [$];
  int    fail_count = 0;
  int    send_pct   = 0;
  int    stall_pct  = 0;
  int    hold_token = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Timeout guard
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic bit alnum_symbol(input logic [SYM_W-1:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_LO_A && c <= CH_LO_Z) ||
           (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic logic [SYM_W-1:0] digit_symbol(input int k);
    return alpha_word_m[k / 8][(k % 8) * SYM_W +: SYM_W];
  endfunction

  function automatic bit alphabet_valid();
    int i, j;
    if (radix_len_m < 2 || radix_len_m > MAX_RADIX_DEF)
      return 1'b0;
    for (i = 0; i < radix_len_m; i++) begin
      if (!alnum_symbol(digit_symbol(i)))
        return 1'b0;
      for (j = i + 1; j < radix_len_m; j++)
        if (digit_symbol(j) == digit_symbol(i))
          return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue the characters one value turns into under the current alphabet
  function automatic void render_value(input logic [DATA_W-1:0] raw);
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] radix;
    int                digits [$];
    int                k;
    if (!alphabet_valid()) begin
      pending_chars.push_back('{CH_NONE, 1'b1, 1'b1});
      return;
    end
    radix = DATA_W'(radix_len_m);
    mag   = raw[DATA_W-1] ? -raw : raw;
    do begin
      digits.push_front(int'(mag % radix));
      mag = mag / radix;
    end while (mag != 0);
    if (raw[DATA_W-1])
      pending_chars.push_back('{CH_MINUS, 1'b0, 1'b0});
    for (k = 0; k < digits.size(); k++)
      pending_chars.push_back('{digit_symbol(digits[k]), k == digits.size() - 1, 1'b0});
  endfunction

  // ------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [SYM_W-1:0] want,
                             input logic [SYM_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    char_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_chars.size() == 0) begin
        $error("result with no character pending: symbol %0h last %0b bad %0b",
               out_ch.symbol, out_ch.is_last, out_ch.bad_alphabet);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        check_field("symbol", want.symbol, out_ch.symbol);
        check_field("is_last", SYM_W'(want.is_last), SYM_W'(out_ch.is_last));
        check_field("bad_alphabet", SYM_W'(want.bad_alphabet), SYM_W'(out_ch.bad_alphabet));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever the token moves
  initial begin : drive_ready
    int hold_seen;
    hold_seen    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // -------------------------------------------------------------- drivers

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SEND: begin send_pct = 84; stall_pct = 0;  end
      IDLE_RECV: begin send_pct = 0;  stall_pct = 84; end
      IDLE_BOTH: begin send_pct = 25; stall_pct = 25; end
      default:   begin send_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx < ALPHA_WORDS)
      alpha_word_m[idx] = data;
    else if (idx == CFG_RADIX_LEN)
      radix_len_m = data[LEN_W-1:0];
    @(negedge clk);
  endtask

  // Load alpha_buf and a radix length; spare indexes get junk on the way
  task automatic write_alphabet(input logic [LEN_W-1:0] len);
    logic [WORD_W-1:0] word;
    int                w, b;
    for (w = 0; w < ALPHA_WORDS; w++) begin
      for (b = 0; b < WORD_W / SYM_W; b++)
        word[b * SYM_W +: SYM_W] = alpha_buf[w * (WORD_W / SYM_W) + b];
      write_reg(w[CFG_IDX_W-1:0], word);
    end
    write_reg(REG_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_SPARE_HI, {$urandom, $urandom});
    word = {$urandom, $urandom};
    word[LEN_W-1:0] = len;
    write_reg(CFG_RADIX_LEN, word);
    cfg_we <= 1'b0;
  endtask

  // Offer one value, queue its expected text on acceptance
  task automatic send_value(input logic [DATA_W-1:0] v, input row_kind_t kind,
                            input string text);
    int c;
    while ($urandom_range(0, 99) < send_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    case (kind)
      ROW_TEXT:
        for (c = 0; c < text.len(); c++)
          pending_chars.push_back('{text[c], c == text.len() - 1, 1'b0});
      ROW_BAD:
        pending_chars.push_back('{CH_NONE, 1'b1, 1'b1});
      default:
        render_value(v);
    endcase
    @(negedge clk);
  endtask

  // Drop valid and let every pending character drain
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_chars.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ------------------------------------------------------------- stimulus

  initial begin : stimulus
    alpha_spec_t       specs [11];
    row_t              rows [24];
    logic [SYM_W-1:0]  pool [62];
    logic [SYM_W-1:0]  odd_bytes [11];
    logic [SYM_W-1:0]  tmp;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] v;
    flaw_t             flaw;
    int                i, j, a, blk, cur_alpha;

    in_ch.valid = 1'b0;
    in_ch.value = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    rst_n       = 1'b0;
    for (a = 0; a < ALPHA_WORDS; a++)
      alpha_word_m[a] = '0;
    radix_len_m = '0;

    specs = '{
      '{"", 6'd0, 8'h00},
      '{"0123456789", 6'd10, 8'h00},
      '{"01", 6'd2, 8'hff},
      '{"0123456789abcdefghijklmnopqrstuvwxyzABCD", 6'd40, 8'h00},
      '{"0123456789abcdefghijklmnopqrstuvwxyzABCD", 6'd41, 8'h00},
      '{"0123456789abcdefghijklmnopqrstuvwxyzABCD", 6'd63, 8'h00},
      '{"0120", 6'd4, 8'h00},
      '{"01", 6'd3, 8'h00},
      '{"0+", 6'd2, 8'h00},
      '{"01", 6'd1, 8'h61},
      '{"ZYXWVUTSRQPONMLKJIHGFEDCBAzyxwvutsrqa980", 6'd16, 8'h00}
    };

    rows = '{
      '{0, 32'h0000_0000, ROW_BAD, ""},
      '{0, 32'h8000_0000, ROW_BAD, ""},
      '{1, 32'h0000_0000, ROW_TEXT, "0"},
      '{1, 32'h7fff_ffff, ROW_TEXT, "2147483647"},
      '{1, 32'h8000_0000, ROW_TEXT, "-2147483648"},
      '{1, 32'hffff_ffff, ROW_TEXT, "-1"},
      '{1, 32'd907, ROW_PREDICT, ""},
      '{2, 32'h0000_0000, ROW_TEXT, "0"},
      '{2, 32'h7fff_ffff, ROW_TEXT, "1111111111111111111111111111111"},
      '{2, 32'h8000_0000, ROW_TEXT, "-10000000000000000000000000000000"},
      '{2, 32'd5, ROW_PREDICT, ""},
      '{3, 32'd39, ROW_TEXT, "D"},
      '{3, 32'd40, ROW_TEXT, "10"},
      '{3, 32'h8000_0000, ROW_PREDICT, ""},
      '{3, 32'h7fff_ffff, ROW_PREDICT, ""},
      '{4, 32'd1, ROW_BAD, ""},
      '{5, 32'd1, ROW_BAD, ""},
      '{6, 32'd7, ROW_BAD, ""},
      '{7, 32'd7, ROW_BAD, ""},
      '{8, 32'd1, ROW_BAD, ""},
      '{9, 32'd1, ROW_BAD, ""},
      '{10, 32'h5555_5555, ROW_PREDICT, ""},
      '{10, -32'sd12345, ROW_PREDICT, ""},
      '{10, 32'haaaa_aaaa, ROW_PREDICT, ""}
    };

    // Bytes just outside the letter and digit ranges, plus high-bit aliases
    odd_bytes = '{8'h2f, 8'h3a, 8'h40, 8'h5b, 8'h60, 8'h7b, 8'h00, 8'hff, 8'h2d,
                  8'hb0, 8'he1};

    // Pool of all 62 legal symbols
    j = 0;
    for (a = 0; a < 10; a++) begin pool[j] = SYM_W'(CH_0 + a);    j++; end
    for (a = 0; a < 26; a++) begin pool[j] = SYM_W'(CH_LO_A + a); j++; end
    for (a = 0; a < 26; a++) begin pool[j] = SYM_W'(CH_UP_A + a); j++; end

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table; the first rows run on the reset alphabet
    set_idle(IDLE_NONE);
    cur_alpha = 0;
    for (i = 0; i < $size(rows); i++) begin
      if (rows[i].alpha != cur_alpha) begin
        wait_idle();
        cur_alpha = rows[i].alpha;
        for (a = 0; a < ALPHA_SYMS; a++)
          alpha_buf[a] = (a < specs[cur_alpha].syms.len()) ?
                         specs[cur_alpha].syms[a] : specs[cur_alpha].fill;
        write_alphabet(specs[cur_alpha].len);
      end
      send_value(rows[i].value, rows[i].kind, rows[i].text);
    end

    // Random blocks, each with a new alphabet and idling mix
    for (blk = 0; blk < RAND_BLOCKS; blk++) begin
      wait_idle();
      set_idle(idle_mode_t'(blk % 4));

      // Shuffle the pool and take a prefix as the alphabet
      for (i = 61; i > 0; i--) begin
        j       = $urandom_range(0, i);
        tmp     = pool[i];
        pool[i] = pool[j];
        pool[j] = tmp;
      end
      case ($urandom_range(0, 4))
        0:       len = 6'd2;
        1:       len = 6'd40;
        default: len = LEN_W'($urandom_range(2, 40));
      endcase
      for (a = 0; a < ALPHA_SYMS; a++)
        alpha_buf[a] = (a >= len && $urandom_range(0, 1)) ? SYM_W'($urandom) : pool[a];

      case ($urandom_range(0, 9))
        7:       flaw = FLAW_DUP;
        8:       flaw = FLAW_CHAR;
        9:       flaw = FLAW_LEN;
        default: flaw = FLAW_NONE;
      endcase
      case (flaw)
        FLAW_DUP: begin
          i = $urandom_range(0, len - 2);
          j = $urandom_range(i + 1, len - 1);
          alpha_buf[j] = alpha_buf[i];
        end
        FLAW_CHAR:
          alpha_buf[$urandom_range(0, len - 1)] = odd_bytes[$urandom_range(0, 10)];
        FLAW_LEN:
          case ($urandom_range(0, 3))
            0:       len = 6'd0;
            1:       len = 6'd1;
            2:       len = 6'd41;
            default: len = LEN_W'($urandom_range(42, 63));
          endcase
        default: ;
      endcase
      write_alphabet(len);

      // Long receiver hold-off so the block backs up into its input
      if (blk % 8 == 5)
        hold_token++;

      repeat ((flaw == FLAW_NONE) ? BLOCK_ITEMS : BAD_ITEMS) begin
        case ($urandom_range(0, 5))
          2:       v = $urandom_range(0, len * len);
          3:       v = -DATA_W'($urandom_range(0, len * len));
          4:
            case ($urandom_range(0, 4))
              0:       v = 32'h0000_0000;
              1:       v = 32'h7fff_ffff;
              2:       v = 32'h8000_0000;
              3:       v = 32'hffff_ffff;
              default: v = 32'h0000_0001;
            endcase
          5:       v = $urandom >> $urandom_range(0, 31);
          default: v = $urandom;
        endcase
        send_value(v, ROW_PREDICT, "");
      end
    end

    wait_idle();
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
src/ritt_pkg.sv
src/ritt_in_if.sv
src/ritt_out_if.sv
src/ritt_div.sv
src/radix_integer_to_text.sv
tb/testbench.sv
